// ===== src/bdq_pkg.sv =====
// shared types and constants for the bounded double-ended queue
package bdq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_WIDTH-1:0]         count_t;

  // request codes
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // operation broadcast to every cell, at most one bit set
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_op_t;

  // summary of the cell row seen by the control logic
  typedef struct packed {
    logic full;
    logic empty;
  } chain_status_t;

endpackage

// ===== src/bdq_if.sv =====
// request and response channel interfaces
interface bdq_req_if;
  import bdq_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  word_t push_word;

  modport source (output valid, output kind, output push_word, input ready);
  modport sink   (input valid, input kind, input push_word, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic    valid;
  logic    ready;
  word_t   pop_word;
  status_t status;
  count_t  occupancy;
  logic    is_empty;

  modport source (output valid, output pop_word, output status, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input pop_word, input status, input occupancy,
                  input is_empty, output ready);
endinterface

// ===== src/bounded_double_ended_queue_top.sv =====
// top level of the bounded double-ended queue
//
// Requests arrive on req (kind, push_word); each gives exactly one response
// on rsp (pop_word, status, occupancy, is_empty). Kinds: push front, push
// back, pop front, pop back. A pop on an empty queue answers with the empty
// status and a zero word; a push onto a full queue is dropped with the full
// status. Occupancy and the empty flag describe the queue after the request.
// Storage is a row of DEPTH cells, front word in cell zero; a front push or
// pop shifts every cell by one place toward its neighbor; a back push fills
// only the first free cell and a back pop frees only the last occupied cell.
// The response is registered at the edge that takes the request. Throughput
// is one transaction per cycle while rsp.ready takes each response, set by
// the single response register. A stalled response holds its register and
// req.ready drops until rsp.ready takes it; a new request is taken in the same
// cycle that the waiting response leaves. Reset empties the queue and clears
// the response valid; no clearing pass is needed.
module bounded_double_ended_queue_top (
  input  logic            clk,
  input  logic            rst,
  bdq_req_if.sink         req,
  bdq_rsp_if.source       rsp
);
  import bdq_pkg::*;

  logic          accept;
  logic          is_push;
  logic          err_full;
  logic          err_empty;
  cell_op_t      op;
  word_t         front_word;
  word_t         back_word;
  chain_status_t chain_status;
  count_t        count;
  count_t        count_next;
  word_t         pop_word_next;
  status_t       status_next;

  assign accept    = req.valid & req.ready;
  assign req.ready = ~rsp.valid | rsp.ready;

  // request decode and error checks
  always_comb begin
    is_push   = req.kind inside {KIND_PUSH_FRONT, KIND_PUSH_BACK};
    err_full  = is_push & chain_status.full;
    err_empty = ~is_push & chain_status.empty;
    op        = '0;
    if (accept && !err_full && !err_empty) begin
      case (req.kind)
        KIND_PUSH_FRONT: op.push_front = 1'b1;
        KIND_PUSH_BACK:  op.push_back  = 1'b1;
        KIND_POP_FRONT:  op.pop_front  = 1'b1;
        KIND_POP_BACK:   op.pop_back   = 1'b1;
        default:         op            = '0;
      endcase
    end
  end

  bdq_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .push_word  (req.push_word),
    .front_word (front_word),
    .back_word  (back_word),
    .status     (chain_status)
  );

  // response payload and occupancy after the request
  always_comb begin
    count_next    = count;
    pop_word_next = '0;
    status_next   = STATUS_OK;
    if (err_full) begin
      status_next = STATUS_FULL;
    end else if (err_empty) begin
      status_next = STATUS_EMPTY;
    end else if (is_push) begin
      count_next = count + count_t'(1);
    end else begin
      count_next    = count - count_t'(1);
      pop_word_next = (req.kind == KIND_POP_FRONT) ? front_word : back_word;
    end
  end

  // occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // response register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.pop_word  <= pop_word_next;
      rsp.status    <= status_next;
      rsp.occupancy <= count_next;
      rsp.is_empty  <= (count_next == '0);
    end
  end

endmodule

// ===== src/bdq_cell.sv =====
// one storage cell of the queue row: a word, an occupied bit, neighbor moves
module bdq_cell (
  input  logic              clk,
  input  logic              rst,
  input  bdq_pkg::cell_op_t op,
  input  bdq_pkg::word_t    push_word,
  input  bdq_pkg::word_t    left_data,
  input  logic              left_occ,
  input  bdq_pkg::word_t    right_data,
  input  logic              right_occ,
  output bdq_pkg::word_t    data,
  output logic              occ,
  output logic              last
);
  import bdq_pkg::*;

  logic back_slot;

  // last occupied cell of the row, and first free cell after it
  assign last      = occ & ~right_occ;
  assign back_slot = ~occ & left_occ;

  // occupied bit
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (op.push_front) begin
      occ <= left_occ;
    end else if (op.pop_front) begin
      occ <= right_occ;
    end else if (op.push_back && back_slot) begin
      occ <= 1'b1;
    end else if (op.pop_back && last) begin
      occ <= 1'b0;
    end
  end

  // stored word
  always_ff @(posedge clk) begin
    if (op.push_front) begin
      data <= left_data;
    end else if (op.pop_front) begin
      data <= right_data;
    end else if (op.push_back && back_slot) begin
      data <= push_word;
    end
  end

endmodule

// ===== src/bdq_chain.sv =====
// row of queue cells, front at cell zero, with front and back word taps
module bdq_chain (
  input  logic                   clk,
  input  logic                   rst,
  input  bdq_pkg::cell_op_t      op,
  input  bdq_pkg::word_t         push_word,
  output bdq_pkg::word_t         front_word,
  output bdq_pkg::word_t         back_word,
  output bdq_pkg::chain_status_t status
);
  import bdq_pkg::*;

  word_t            cell_data [DEPTH];
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_last;

  // cells with neighbor wiring; the row edges feed the push word and empties
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t ldata;
    logic  locc;
    word_t rdata;
    logic  rocc;

    if (i == 0) begin : g_first
      assign ldata = push_word;
      assign locc  = 1'b1;
    end else begin : g_inner_left
      assign ldata = cell_data[i-1];
      assign locc  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rdata = '0;
      assign rocc  = 1'b0;
    end else begin : g_inner_right
      assign rdata = cell_data[i+1];
      assign rocc  = cell_occ[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .push_word  (push_word),
      .left_data  (ldata),
      .left_occ   (locc),
      .right_data (rdata),
      .right_occ  (rocc),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .last       (cell_last[i])
    );
  end

  // back word: or of the cells, only the last occupied one contributes
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (cell_data[i] & {DATA_WIDTH{cell_last[i]}});
    end
  end

  assign front_word   = cell_data[0];
  assign status.full  = cell_occ[DEPTH-1];
  assign status.empty = ~cell_occ[0];

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the bounded double-ended queue
module testbench;
  import bdq_pkg::*;

  // one expected response
  typedef struct {
    word_t   pop_word;
    status_t status;
    count_t  occupancy;
    logic    is_empty;
  } deque_result_t;

  logic clk;
  logic rst;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_double_ended_queue_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow model of the queue, kept as a circular buffer
  word_t shadow_slots [DEPTH];
  int    shadow_front;
  int    shadow_count;

  deque_result_t pending_results [$];
  int            mismatch_count;

  // idling controls, shared with the sender and the receiver
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_request;
  int  hold_left;
  bit  filling;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // apply one request to the shadow queue and work out its response
  function automatic deque_result_t apply_request(kind_t k, word_t w);
    deque_result_t r;
    int            idx;
    r.pop_word = '0;
    r.status   = STATUS_OK;
    case (k)
      KIND_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_slots[shadow_front] = w;
          shadow_count++;
        end
      end
      KIND_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          shadow_slots[(shadow_front + shadow_count) % DEPTH] = w;
          shadow_count++;
        end
      end
      KIND_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.pop_word   = shadow_slots[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          idx        = (shadow_front + shadow_count - 1) % DEPTH;
          r.pop_word = shadow_slots[idx];
          shadow_count--;
        end
      end
    endcase
    r.occupancy = count_t'(shadow_count);
    r.is_empty  = (shadow_count == 0);
    return r;
  endfunction

  // word with a bias toward the extremes
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // kind that sweeps the queue between empty and full, with some noise
  function automatic kind_t pick_kind();
    bit is_push;
    if (shadow_count == DEPTH) filling = 1'b0;
    if (shadow_count == 0) filling = 1'b1;
    if ($urandom_range(9) == 0) return kind_t'($urandom_range(3));
    is_push = ($urandom_range(99) < (filling ? 70 : 30));
    if (is_push) return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  // offer one request, wait for its transaction, record the expected response
  task automatic send_request(input kind_t k, input word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= k;
    req_ch.push_word <= w;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_request(k, w));
  endtask

  // stop offering and wait for every outstanding response
  task automatic wait_drained();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (pending_results.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() > 0) begin
      $error("responses still outstanding: %0d", pending_results.size());
      mismatch_count++;
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  initial begin
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // response checker
  initial begin
    deque_result_t exp_r;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp_ch.pop_word !== exp_r.pop_word) begin
            $error("pop_word expected %0d got %0d", exp_r.pop_word, rsp_ch.pop_word);
            mismatch_count++;
          end
          if (rsp_ch.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, rsp_ch.status);
            mismatch_count++;
          end
          if (rsp_ch.occupancy !== exp_r.occupancy) begin
            $error("occupancy expected %0d got %0d", exp_r.occupancy, rsp_ch.occupancy);
            mismatch_count++;
          end
          if (rsp_ch.is_empty !== exp_r.is_empty) begin
            $error("is_empty expected %0d got %0d", exp_r.is_empty, rsp_ch.is_empty);
            mismatch_count++;
          end
        end
      end
    end
  end

  // extreme words at both ends, then pops on an empty queue
  task automatic test_extremes_and_empty();
    send_request(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_request(KIND_PUSH_BACK, 32'sh7fff_ffff);
    send_request(KIND_POP_FRONT, '1);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_POP_FRONT, 32'sh5555_aaaa);
    send_request(KIND_POP_BACK, 32'shaaaa_5555);
    wait_drained();
  endtask

  // fill from both ends, then push on a full queue at each end
  task automatic test_full_rejects();
    word_t w;
    for (int i = 0; i < DEPTH; i++) begin
      w = (i == 0) ? word_t'('1) : (i == DEPTH - 1) ? word_t'('0) : pick_word();
      send_request((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, w);
    end
    send_request(KIND_PUSH_FRONT, 32'sh1234_5678);
    send_request(KIND_PUSH_BACK, 32'sh8765_4321);
    wait_drained();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_response_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 60;
    for (int i = 0; i < 12; i++) send_request(pick_kind(), pick_word());
    wait_drained();
  endtask

  // sweeps of random requests under one idling setting
  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send_request(pick_kind(), pick_word());
    wait_drained();
  endtask

  // main sequence
  initial begin
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.kind      <= KIND_PUSH_FRONT;
    req_ch.push_word <= '0;
    shadow_front   = 0;
    shadow_count   = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    filling        = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes_and_empty();
    test_full_rejects();
    test_random_traffic(90, 0, 0);
    test_response_backpressure();
    test_random_traffic(90, 80, 0);
    test_random_traffic(90, 0, 80);
    test_random_traffic(90, 24, 24);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
